// ===== rtl/rsbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbl_pkg
// Shared types and constants of the relay switch back-off limiter.
// ----------------------------------------------------------------------------
package rsbl_pkg;

  // Widths of the transaction fields.
  localparam int unsigned NowW       = 32;
  localparam int unsigned RelayVecW  = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  // Hold-off delay: 1 up to 512 in ten bits.
  localparam int unsigned DelayW     = 10;
  localparam logic [DelayW-1:0] DelayGrowLimit = DelayW'(5 * 60);
  localparam logic [DelayW-1:0] DelayMin       = DelayW'(1);

  // Defaults for the top-level parameters.
  localparam int unsigned NumRelaysDef = 8;
  localparam int unsigned TimeBitsDef  = 32;

  // Configuration register defaults after reset.
  localparam logic [CountW-1:0]    RelayCountRst = CountW'(8);
  localparam logic [RelayVecW-1:0] EnabledRst    = '0;
  localparam logic [RelayVecW-1:0] NcRst         = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RELAY_COUNT = 2'd0,
    CFG_ENABLED     = 2'd1,
    CFG_NORM_CLOSED = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [NowW-1:0]      now_seconds;
    logic [RelayVecW-1:0] desired_states;
  } in_item_t;

  typedef struct packed {
    logic [RelayVecW-1:0] relay_states;
    logic [RelayVecW-1:0] drive_levels;
    logic                 any_switched;
  } out_item_t;

  // What one lane reports to the merging stage.
  typedef struct packed {
    logic held;
    logic switched;
  } lane_stat_t;

endpackage

// ===== rtl/rsbl_lane.sv =====
// ----------------------------------------------------------------------------
// rsbl_lane
// One relay: held state, time stamp of the last switch and hold-off delay.
// ----------------------------------------------------------------------------
module rsbl_lane #(
  parameter int unsigned TIME_BITS = rsbl_pkg::TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 active_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 desired_i,
  output rsbl_pkg::lane_stat_t stat_o
);
  import rsbl_pkg::*;

  logic                 held_q, held_d;
  logic [TIME_BITS-1:0] stamp_q, stamp_d;
  logic [DelayW-1:0]    delay_q, delay_d;
  logic [TIME_BITS-1:0] elapsed;
  logic                 can_switch;
  logic                 do_switch;

  assign elapsed    = now_i - stamp_q;
  assign can_switch = elapsed > TIME_BITS'(delay_q);
  assign do_switch  = active_i && (held_q != desired_i) && can_switch;

  always_comb begin
    held_d  = held_q;
    stamp_d = stamp_q;
    delay_d = delay_q;
    if (step_i && active_i) begin
      if (held_q != desired_i) begin
        if (can_switch) begin
          held_d  = desired_i;
          stamp_d = now_i;
          if (delay_q < DelayGrowLimit) begin
            delay_d = {delay_q[DelayW-2:0], 1'b0};
          end
        end
      end else if ((elapsed > TIME_BITS'({delay_q, 1'b0})) && (delay_q > DelayMin)) begin
        delay_d = delay_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      stamp_q <= '0;
      delay_q <= DelayMin;
    end else begin
      held_q  <= held_d;
      stamp_q <= stamp_d;
      delay_q <= delay_d;
    end
  end

  assign stat_o.held     = held_d;
  assign stat_o.switched = step_i && do_switch;

  // The delay is always a power of two between 1 and 512.
  a_delay_pow2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(delay_q))
    else $error("hold-off delay is not a power of two");

  // A reported switch flips the held state.
  a_switch_flips : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.switched |=> (held_q != $past(held_q)))
    else $error("switch reported without a state change");

  // A relay that is not in use keeps its stamp and delay.
  a_idle_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_i |=> ($stable(stamp_q) && $stable(delay_q)))
    else $error("relay not in use changed its state");

endmodule

// ===== rtl/rsbl_merge.sv =====
// ----------------------------------------------------------------------------
// rsbl_merge
// Combines the lane reports into one result and holds it in a two-entry
// output buffer.
// ----------------------------------------------------------------------------
module rsbl_merge #(
  parameter int unsigned NUM_RELAYS = rsbl_pkg::NumRelaysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  rsbl_pkg::lane_stat_t          lane_i [NUM_RELAYS],
  input  logic [rsbl_pkg::RelayVecW-1:0] nc_mask_i,
  output logic                          full_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rsbl_pkg::out_item_t           out_data_o
);
  import rsbl_pkg::*;

  out_item_t            res;
  logic [RelayVecW-1:0] states;
  logic [RelayVecW-1:0] used;
  logic                 any_sw;

  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;
  logic      take;

  always_comb begin
    states = '0;
    used   = '0;
    any_sw = 1'b0;
    for (int i = 0; i < NUM_RELAYS; i++) begin
      states[i] = lane_i[i].held;
      used[i]   = 1'b1;
      any_sw    = any_sw | lane_i[i].switched;
    end
    res.relay_states = states;
    res.drive_levels = (states ^ nc_mask_i) & used;
    res.any_switched = any_sw;
  end

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (step_i) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (step_i) begin
      if (!out_valid_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The second entry only fills behind a waiting first entry.
  a_skid_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("buffer entry held without an output result");

  // Nothing is taken in while the buffer is full.
  a_no_step_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !step_i)
    else $error("transaction accepted with a full output buffer");

endmodule

// ===== rtl/relay_switch_backoff_limiter.sv =====
// ----------------------------------------------------------------------------
// relay_switch_backoff_limiter
// Relay switching limiter with exponential hold-off per relay.
// ----------------------------------------------------------------------------
// Each input transaction is one evaluation tick: the current time in seconds
// and the requested on/off state of every relay. Each output transaction is
// the held relay states, the pin drive levels and a flag that tells whether
// any relay switched on this tick. Exactly one output follows each input.
// Configuration (relay count, enable mask, normally-closed mask) is written
// through a separate valid/ready port that is always ready; write it only
// while no tick is in flight.
// An accepted tick's result is registered in the output register, or in the
// skid entry behind a waiting result. One tick is taken every cycle while
// there is room; the limit is the per-relay time subtract and compare, which
// all relays do side by side. Reset turns all relays off, clears their time
// stamps, sets every delay to one second, and restores count 8 with no relay
// enabled. When the receiver stalls, up to two results are held in an output
// register and a skid entry; the input stalls only once both are occupied.
// ----------------------------------------------------------------------------
module relay_switch_backoff_limiter #(
  parameter int unsigned NUM_RELAYS = rsbl_pkg::NumRelaysDef,
  parameter int unsigned TIME_BITS  = rsbl_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Tick input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rsbl_pkg::in_item_t            in_data_i,
  // Result output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rsbl_pkg::out_item_t           out_data_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsbl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rsbl_pkg::CfgDataW-1:0] cfg_data_i
);
  import rsbl_pkg::*;

  logic [CountW-1:0]    relay_count_q;
  logic [RelayVecW-1:0] enabled_q;
  logic [RelayVecW-1:0] nc_mask_q;

  logic                 step;
  logic                 full;
  logic [TIME_BITS-1:0] now;
  lane_stat_t           lane_stat [NUM_RELAYS];

  // The configuration port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_count_q <= RelayCountRst;
      enabled_q     <= EnabledRst;
      nc_mask_q     <= NcRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RELAY_COUNT: relay_count_q <= cfg_data_i[CountW-1:0];
        CFG_ENABLED:     enabled_q     <= cfg_data_i;
        CFG_NORM_CLOSED: nc_mask_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A tick is taken whenever the output buffer still has room.
  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  // Time differences wrap at the stored stamp width.
  assign now = TIME_BITS'(in_data_i.now_seconds);

  // One lane per relay. A relay is in use when its index is below the
  // configured count and its enable bit is set; the count clips naturally
  // because lane indices never reach NUM_RELAYS.
  for (genvar g = 0; g < NUM_RELAYS; g++) begin : g_lane
    logic active;
    assign active = (relay_count_q > CountW'(g)) && enabled_q[g];

    rsbl_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (step),
      .active_i  (active),
      .now_i     (now),
      .desired_i (in_data_i.desired_states[g]),
      .stat_o    (lane_stat[g])
    );
  end

  // Merges the lane reports and buffers the result.
  rsbl_merge #(
    .NUM_RELAYS(NUM_RELAYS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .lane_i      (lane_stat),
    .nc_mask_i   (nc_mask_q),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the relay switch back-off limiter.
// ----------------------------------------------------------------------------
// Ticks go in on the input channel and are mirrored by a shadow copy of the
// per-relay hold-off logic. The checker compares every result against the
// oldest predicted status. A short directed part covers the delay ramp and
// its bounds, a clock stepping back, count clipping and the masks. A long
// random part follows, with several register settings and random gaps on
// both channels.
// ----------------------------------------------------------------------------
module testbench;
  import rsbl_pkg::*;

  // Index 3 is not a register; writes to it must leave everything unchanged.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Tick channel, result channel and register write channel.
  logic                tick_valid = 1'b0;
  in_item_t            tick_data  = '0;
  logic                tick_stall;
  logic                status_valid;
  logic                status_stall = 1'b0;
  out_item_t           status_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Shadow copy of the registers and the per-relay state.
  logic [CountW-1:0]    shadow_count;
  logic [RelayVecW-1:0] shadow_enabled;
  logic [RelayVecW-1:0] shadow_nc;
  logic [RelayVecW-1:0] shadow_held;
  logic [NowW-1:0]      shadow_stamp [RelayVecW];
  logic [DelayW-1:0]    shadow_delay [RelayVecW];

  // Statuses predicted for accepted ticks, oldest first.
  out_item_t   expected_status_q [$];
  int unsigned fail_count = 0;

  // Percent chance per decision that the sender idles or the receiver stalls.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int          stall_left = 0;

  // Time and requested states that the random traffic walks through.
  logic [NowW-1:0]      clock_s;
  logic [RelayVecW-1:0] wanted;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  relay_switch_backoff_limiter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tick_valid),
    .in_stall_o  (tick_stall),
    .in_data_i   (tick_data),
    .out_valid_o (status_valid),
    .out_stall_i (status_stall),
    .out_data_o  (status_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Gap length in cycles: mostly a few, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(99) < 88) begin
      return $urandom_range(4, 1);
    end
    return $urandom_range(60, 12);
  endfunction

  // Applies one tick to the shadow state and returns the status it yields.
  // Relays past the clipped count or with their enable bit clear are left
  // untouched. Elapsed time wraps at 32 bits, so a clock that steps back
  // looks like a very long wait.
  function automatic out_item_t advance_relays(input in_item_t tick);
    out_item_t       status;
    int unsigned     in_use;
    logic [NowW-1:0] elapsed;
    logic            switched;
    switched = 1'b0;
    in_use = (shadow_count > NumRelaysDef) ? NumRelaysDef : shadow_count;
    for (int i = 0; i < in_use; i++) begin
      if (!shadow_enabled[i]) continue;
      elapsed = tick.now_seconds - shadow_stamp[i];
      if (shadow_held[i] != tick.desired_states[i]) begin
        if (elapsed > {22'd0, shadow_delay[i]}) begin
          shadow_held[i]  = tick.desired_states[i];
          shadow_stamp[i] = tick.now_seconds;
          switched = 1'b1;
          if (shadow_delay[i] < DelayGrowLimit) begin
            shadow_delay[i] = shadow_delay[i] << 1;
          end
        end
      end else if (elapsed > {21'd0, shadow_delay[i], 1'b0} &&
                   shadow_delay[i] > DelayMin) begin
        shadow_delay[i] = shadow_delay[i] >> 1;
      end
    end
    status.relay_states = shadow_held;
    status.drive_levels = shadow_held ^ shadow_nc;
    status.any_switched = switched;
    return status;
  endfunction

  // The receiver stalls in bursts whose odds are set by stall_pct.
  always @(posedge clk) begin
    if (!rst_n) begin
      status_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      status_stall <= 1'b1;
      stall_left   <= pick_gap() - 1;
    end else begin
      status_stall <= 1'b0;
    end
  end

  // Every accepted result is matched against the oldest prediction. Values
  // read right after the edge are the ones that the edge sampled.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && status_valid === 1'b1 && !status_stall) begin
      if (expected_status_q.size() == 0) begin
        $error("result with no tick waiting: %h", status_data);
        fail_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (status_data.relay_states !== want.relay_states) begin
          $error("relay_states: expected %h, got %h",
                 want.relay_states, status_data.relay_states);
          fail_count++;
        end
        if (status_data.drive_levels !== want.drive_levels) begin
          $error("drive_levels: expected %h, got %h",
                 want.drive_levels, status_data.drive_levels);
          fail_count++;
        end
        if (status_data.any_switched !== want.any_switched) begin
          $error("any_switched: expected %b, got %b",
                 want.any_switched, status_data.any_switched);
          fail_count++;
        end
      end
    end
  end

  // Sends one tick, possibly after an idle gap. Valid stays high when the
  // task returns, so back-to-back ticks keep it high; a caller that stops
  // sending lowers it through await_results.
  task automatic send_tick(input logic [NowW-1:0] now_s,
                           input logic [RelayVecW-1:0] desired);
    in_item_t tick;
    int       gap;
    tick.now_seconds    = now_s;
    tick.desired_states = desired;
    gap = ($urandom_range(99) < idle_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data  <= tick;
    @(posedge clk);
    while (tick_stall !== 1'b0) @(posedge clk);
    expected_status_q.push_back(advance_relays(tick));
  endtask

  // Stops sending and waits until every predicted status has come back.
  // Each tick gives exactly one result, so nothing is in flight after that.
  task automatic await_results();
    tick_valid <= 1'b0;
    do @(posedge clk); while (expected_status_q.size() != 0);
  endtask

  // Writes one register and mirrors it. Valid is left high for a following
  // write; the caller lowers it after the last one.
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_RELAY_COUNT: shadow_count   = data[CountW-1:0];
      CFG_ENABLED:     shadow_enabled = data;
      CFG_NORM_CLOSED: shadow_nc      = data;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [CfgDataW-1:0] count,
                           input logic [CfgDataW-1:0] enabled,
                           input logic [CfgDataW-1:0] nc);
    write_cfg(CFG_RELAY_COUNT, count);
    write_cfg(CFG_ENABLED, enabled);
    write_cfg(CFG_NORM_CLOSED, nc);
    cfg_valid <= 1'b0;
  endtask

  // Out of reset no relay is enabled, so requests must not move anything.
  task automatic test_disabled_after_reset();
    send_tick('0, '1);
    send_tick('1, '1);
    send_tick(32'h8000_0000, 8'h5A);
    await_results();
  endtask

  // All relays toggle with waits longer than the largest delay, so the delay
  // doubles from one up to its ceiling of 512 and then stays there. Long
  // quiet stretches afterwards halve it again.
  task automatic test_switch_and_delay_ramp();
    apply_cfg(8'd8, 8'hFF, 8'hA5);
    send_tick(32'd0, 8'hFF);   // no time has passed
    send_tick(32'd1, 8'hFF);   // exactly the delay: still held off
    send_tick(32'd2, 8'hFF);   // one past the delay: switches
    send_tick(32'd2, 8'h00);   // right back: held off
    clock_s = 32'd2;
    wanted  = 8'hFF;
    for (int k = 0; k < 10; k++) begin
      clock_s += 32'd600;
      wanted  = ~wanted;
      send_tick(clock_s, wanted);
    end
    for (int k = 0; k < 3; k++) begin
      clock_s += 32'd1100;
      send_tick(clock_s, wanted);
    end
    await_results();
  endtask

  // A clock that steps back gives a wrapped, huge elapsed time.
  task automatic test_time_step_back();
    send_tick(clock_s - 32'd5, ~wanted);
    send_tick(32'hFFFF_FFFF, wanted);
    wanted = ~wanted;
    send_tick(32'd3, wanted);
    await_results();
  endtask

  // Count above eight is clipped, a count of zero freezes everything, a
  // partial count and partial enables leave the other relays alone, and a
  // write to the spare index changes nothing.
  task automatic test_count_clip_and_masks();
    apply_cfg(8'hFB, 8'hFF, 8'hFF);
    send_tick(32'h0001_0000, 8'h0F);
    await_results();
    apply_cfg(8'd0, 8'hFF, 8'h00);
    send_tick(32'h0002_0000, 8'hF0);
    await_results();
    write_cfg(CFG_RELAY_COUNT, 8'd3);
    write_cfg(CFG_ENABLED, 8'h05);
    write_cfg(CfgIdxSpare, 8'hFF);
    cfg_valid <= 1'b0;
    send_tick(32'h0003_0000, 8'hFF);
    send_tick(32'h0004_0000, 8'h00);
    await_results();
  endtask

  // One phase of random traffic under one register setting. Time mostly
  // creeps forward at the scale of the delays, so relays are often held off
  // and delays both grow and shrink; now and then it jumps anywhere.
  task automatic random_phase(input int ticks, input logic [CfgDataW-1:0] count,
                              input logic [CfgDataW-1:0] enabled,
                              input logic [CfgDataW-1:0] nc,
                              input int unsigned idle, input int unsigned stall);
    int unsigned     pick;
    logic [NowW-1:0] step;
    await_results();
    apply_cfg(count, enabled, nc);
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < ticks; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) step = $urandom_range(3);
      else if (pick < 75) step = $urandom_range(40);
      else if (pick < 95) step = $urandom_range(1100, 100);
      else step = $urandom;
      clock_s += step;
      pick = $urandom_range(99);
      if (pick < 65) wanted ^= RelayVecW'(1) << $urandom_range(RelayVecW - 1);
      else if (pick < 85) wanted = wanted;
      else wanted = RelayVecW'($urandom);
      send_tick(clock_s, wanted);
      // Occasionally hold off until the block has answered everything.
      if ($urandom_range(199) == 0) await_results();
    end
    await_results();
  endtask

  task automatic test_random_traffic();
    random_phase(150, 8'd8, 8'hFF, 8'h00, 0, 0);
    random_phase(150, 8'd8, 8'hFF, 8'hFF, 20, 30);
    clock_s = 32'hFFFF_FC00;   // run across the wrap of the seconds counter
    random_phase(150, 8'hFF, 8'hFF, 8'h5A, 40, 10);
    random_phase(60, 8'd0, 8'hFF, 8'h00, 15, 15);
    random_phase(150, 8'd1, 8'h01, 8'hFF, 10, 40);
    random_phase(150, 8'd5, 8'hC3, 8'h3C, 25, 25);
    random_phase(150, 8'd8, CfgDataW'($urandom), CfgDataW'($urandom), 0, 50);
    random_phase(150, 8'd8, 8'hFF, 8'h00, 50, 0);
    random_phase(150, CfgDataW'($urandom_range(15)), CfgDataW'($urandom),
                 CfgDataW'($urandom), 20, 20);
    random_phase(150, 8'd7, 8'h7F, 8'h81, 5, 5);
  endtask

  initial begin
    shadow_count   = RelayCountRst;
    shadow_enabled = EnabledRst;
    shadow_nc      = NcRst;
    shadow_held    = '0;
    for (int i = 0; i < RelayVecW; i++) begin
      shadow_stamp[i] = '0;
      shadow_delay[i] = DelayMin;
    end
    clock_s = '0;
    wanted  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_after_reset();
    test_switch_and_delay_ramp();
    test_time_step_back();
    test_count_clip_and_masks();
    test_random_traffic();

    // Give a stray extra result a chance to show up before judging.
    await_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_status_q.size() == 0) begin
      $display("relay_switch_backoff_limiter regression: pass");
    end else begin
      $display("relay_switch_backoff_limiter regression: fail");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every tick after a long idle gap and
  // every result behind a long stall.
  initial begin
    #8000000;
    $display("relay_switch_backoff_limiter regression: fail");
    $finish;
  end

endmodule
